// ----- src/atw_pkg.sv -----
// Shared types and constants for the asymmetric tanh waveshaper.
// Standalone package, no dependencies; used by asymmetric_tanh_waveshaper.
package atw_pkg;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_ASYMMETRY = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DRIVE     = 2'd1;

  localparam logic [15:0] ASYMMETRY_RESET = 16'd6554;
  localparam logic [15:0] DRIVE_RESET     = 16'd4096;
  // drive codes at or below this skip the tanh stage
  localparam logic [15:0] DRIVE_BYPASS_MAX = 16'd40;

  localparam int SAMPLE_W = 16;
  localparam int OUT_W    = 17;
  localparam int TANH_W   = 17;          // Q.16 tanh value, 1.0 included
  localparam int QUO_W    = 17;          // quotient bits resolved by the divider
  localparam int NUM_W    = 32;          // dividend width

  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
  localparam logic [TANH_W-1:0] TANH_ONE = 17'd65536;
  localparam logic signed [OUT_W:0] OUT_MAX = 18'sd32767;

  // Per-item sideband that rides along the back half of the pipeline
  typedef struct packed {
    logic                    neg;
    logic                    bypass;
    logic                    ovf;
    logic signed [OUT_W-1:0] y;
  } side_t;

endpackage

// ----- src/asymmetric_tanh_waveshaper.sv -----
// Asymmetric tanh waveshaper: bend, drive, table tanh and normalising divide.
// Depends on atw_pkg (types, constants).
//
//  channel   | signals                                  | direction | handshake
//  ----------+------------------------------------------+-----------+------------------------
//  sample in | start, sample_in, busy                   | in        | start && !busy
//  result    | done, sample_out                         | out       | one-cycle done strobe
//  config    | cfg_valid, cfg_index, cfg_data, cfg_ready| in        | cfg_valid && cfg_ready
//
// One word is taken per cycle while busy is low; each result leaves through seven
// arithmetic/table stages, the dividend stage, 17 divider stages and the output
// register. After reset and after every drive_code write the block holds busy high
// while tanh(drive) is pushed through the table path to form the divisor. Reset is
// synchronous; the result side has no stall, so words never wait.
module asymmetric_tanh_waveshaper #(
  parameter int TANH_POINTS = 256
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic signed [atw_pkg::SAMPLE_W-1:0]   sample_in,
  output logic                                  busy,
  output logic                                  done,
  output logic signed [atw_pkg::OUT_W-1:0]      sample_out,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [atw_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [15:0]                           cfg_data
);

  localparam int IW = $clog2(TANH_POINTS);
  localparam int PW = 30 + IW;
  localparam int QW = atw_pkg::QUO_W;
  localparam int LATENCY = 9 + QW;
  localparam logic [63:0] SPAN = 64'(TANH_POINTS - 1);
  localparam logic [63:0] ONE = atw_pkg::ONE_Q30;

  // ---------------------------------------------------------------------------
  // tanh table, entry i = tanh(8*i/(TANH_POINTS-1)) in Q.16, built at elaboration
  // ---------------------------------------------------------------------------
  logic [atw_pkg::TANH_W-1:0] tanh_rom [TANH_POINTS];

  for (genvar g = 0; g < TANH_POINTS; g++) begin : g_tab
    localparam logic [63:0] R  = ((64'(g) << 26) + SPAN / 64'd2) / SPAN;
    localparam logic [63:0] T1 = (ONE * R) / (64'd1 << 30);
    localparam logic [63:0] T2 = (T1 * R) / (64'd2 << 30);
    localparam logic [63:0] T3 = (T2 * R) / (64'd3 << 30);
    localparam logic [63:0] T4 = (T3 * R) / (64'd4 << 30);
    localparam logic [63:0] T5 = (T4 * R) / (64'd5 << 30);
    localparam logic [63:0] T6 = (T5 * R) / (64'd6 << 30);
    localparam logic [63:0] S0 = ONE - T1 + T2 - T3 + T4 - T5 + T6;
    localparam logic [63:0] E1 = (S0 * S0 + (64'd1 << 29)) >> 30;
    localparam logic [63:0] E2 = (E1 * E1 + (64'd1 << 29)) >> 30;
    localparam logic [63:0] E3 = (E2 * E2 + (64'd1 << 29)) >> 30;
    localparam logic [63:0] E4 = (E3 * E3 + (64'd1 << 29)) >> 30;
    localparam logic [63:0] E5 = (E4 * E4 + (64'd1 << 29)) >> 30;
    localparam logic [63:0] E6 = (E5 * E5 + (64'd1 << 29)) >> 30;
    localparam logic [63:0] E7 = (E6 * E6 + (64'd1 << 29)) >> 30;
    localparam logic [63:0] E8 = (E7 * E7 + (64'd1 << 29)) >> 30;
    localparam logic [63:0] DEN_E = ONE + E8;
    localparam logic [63:0] NUM_E = (ONE - E8) << 16;
    localparam logic [63:0] ENTRY = (NUM_E + DEN_E / 64'd2) / DEN_E;
    assign tanh_rom[g] = ENTRY[atw_pkg::TANH_W-1:0];
  end

  // ---------------------------------------------------------------------------
  // Configuration registers and divisor refresh
  // ---------------------------------------------------------------------------
  logic [15:0]                asymmetry_code;
  logic [15:0]                drive_code;
  logic                       refresh_pending;
  logic [atw_pkg::TANH_W-1:0] den_q;
  logic                       cfg_write;

  assign cfg_ready = 1'b1;   // registers take a word every cycle
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      asymmetry_code  <= atw_pkg::ASYMMETRY_RESET;
      drive_code      <= atw_pkg::DRIVE_RESET;
      refresh_pending <= 1'b1;
    end else begin
      if (refresh_pending) begin
        refresh_pending <= 1'b0;
      end
      if (cfg_write && cfg_index == atw_pkg::REG_ASYMMETRY) begin
        asymmetry_code <= cfg_data;
      end
      if (cfg_write && cfg_index == atw_pkg::REG_DRIVE) begin
        drive_code      <= cfg_data;
        refresh_pending <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline registers
  // ---------------------------------------------------------------------------
  logic                              s1_valid, s1_den;
  logic signed [atw_pkg::SAMPLE_W-1:0] s1_x;
  logic                              s2_valid, s2_den;
  logic signed [atw_pkg::SAMPLE_W-1:0] s2_x;
  logic [30:0]                       s2_sq;
  logic                              s3_valid, s3_den;
  logic signed [atw_pkg::OUT_W-1:0]  s3_y;
  logic                              s4_valid, s4_den, s4_bypass;
  logic signed [32:0]                s4_z;
  logic signed [atw_pkg::OUT_W-1:0]  s4_y;
  logic                              s5_valid, s5_den, s5_sat;
  logic [IW-1:0]                     s5_idx;
  logic [29:0]                       s5_f;
  atw_pkg::side_t                    s5_side;
  logic                              s6_valid, s6_den, s6_sat;
  logic [atw_pkg::TANH_W-1:0]        s6_tlo, s6_thi;
  logic [29:0]                       s6_f;
  atw_pkg::side_t                    s6_side;
  logic                              s7_valid;
  logic [atw_pkg::TANH_W-1:0]        s7_v;
  atw_pkg::side_t                    s7_side;

  logic                              dv_valid [QW+1];
  logic [atw_pkg::NUM_W-1:0]         dv_rem   [QW+1];
  logic [QW-1:0]                     dv_q     [QW+1];
  atw_pkg::side_t                    dv_side  [QW+1];

  assign busy = refresh_pending | s1_den | s2_den | s3_den | s4_den | s5_den | s6_den;

  // Combinational results of each stage
  logic signed [31:0]                x_sq;
  logic [46:0]                       bend_prod;
  logic [47:0]                       bend_sum;
  logic signed [atw_pkg::OUT_W:0]    y_wide;
  logic signed [33:0]                drive_prod;
  logic [32:0]                       z_mag;
  logic [PW-1:0]                     tab_pos;
  logic [IW-1:0]                     s5_idx_hi;
  logic signed [17:0]                tab_diff;
  logic signed [48:0]                tab_prod;
  logic signed [49:0]                tab_acc;
  logic [atw_pkg::TANH_W-1:0]        tanh_v;
  logic [atw_pkg::NUM_W-1:0]         dividend;
  atw_pkg::side_t                    div_side_in;

  assign x_sq       = s1_x * s1_x;
  assign bend_prod  = s2_sq * asymmetry_code;
  assign bend_sum   = {1'b0, bend_prod} + (48'd1 << 30);
  assign y_wide     = $signed({s2_x[atw_pkg::SAMPLE_W-1], s2_x[atw_pkg::SAMPLE_W-1], s2_x})
                    - $signed({1'b0, bend_sum[47:31]});
  assign drive_prod = s3_y * $signed({1'b0, drive_code});
  assign z_mag      = s4_z[32] ? 33'(-s4_z) : 33'(s4_z);
  assign tab_pos    = {{IW{1'b0}}, z_mag[29:0]} * PW'(TANH_POINTS - 1);
  assign s5_idx_hi  = s5_idx + IW'(1);
  assign tab_diff   = $signed({1'b0, s6_thi}) - $signed({1'b0, s6_tlo});
  assign tab_prod   = tab_diff * $signed({1'b0, s6_f});
  assign tab_acc    = $signed({3'b0, s6_tlo, 30'd0}) + 50'(tab_prod) + 50'sd536870912;
  assign tanh_v     = s6_sat ? atw_pkg::TANH_ONE : tab_acc[46:30];
  assign dividend   = {s7_v, 15'd0} + atw_pkg::NUM_W'(den_q >> 1);

  // flag quotients that cannot fit the divider, they clip to 1.0 anyway
  always_comb begin
    div_side_in     = s7_side;
    div_side_in.ovf = {2'b0, dividend[atw_pkg::NUM_W-1:QW]} >= den_q;
  end

  // Valid and refresh-token bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;  s1_den <= 1'b0;
      s2_valid <= 1'b0;  s2_den <= 1'b0;
      s3_valid <= 1'b0;  s3_den <= 1'b0;
      s4_valid <= 1'b0;  s4_den <= 1'b0;
      s5_valid <= 1'b0;  s5_den <= 1'b0;
      s6_valid <= 1'b0;  s6_den <= 1'b0;
      s7_valid <= 1'b0;
      dv_valid[0] <= 1'b0;
    end else begin
      // inject the divisor token ahead of any word
      s1_valid <= refresh_pending | (start & ~busy);
      s1_den   <= refresh_pending;
      s2_valid <= s1_valid;  s2_den <= s1_den;
      s3_valid <= s2_valid;  s3_den <= s2_den;
      s4_valid <= s3_valid;  s4_den <= s3_den;
      s5_valid <= s4_valid;  s5_den <= s4_den;
      s6_valid <= s5_valid;  s6_den <= s5_den;
      s7_valid <= s6_valid & ~s6_den;
      dv_valid[0] <= s7_valid;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    s1_x  <= sample_in;

    s2_x  <= s1_x;
    s2_sq <= x_sq[30:0];

    s3_y  <= y_wide[atw_pkg::OUT_W-1:0];

    s4_y      <= s3_y;
    s4_bypass <= drive_code <= atw_pkg::DRIVE_BYPASS_MAX;
    s4_z      <= s3_den ? $signed({2'b0, drive_code, 15'd0}) : drive_prod[32:0];

    s5_sat         <= |z_mag[32:30];
    s5_idx         <= tab_pos[PW-1:30];
    s5_f           <= tab_pos[29:0];
    s5_side.neg    <= s4_z[32];
    s5_side.bypass <= s4_bypass;
    s5_side.ovf    <= 1'b0;
    s5_side.y      <= s4_y;

    s6_tlo  <= tanh_rom[s5_idx];
    s6_thi  <= tanh_rom[s5_idx_hi];
    s6_f    <= s5_f;
    s6_sat  <= s5_sat;
    s6_side <= s5_side;

    s7_v    <= tanh_v;
    s7_side <= s6_side;

    // a zero divisor cannot arise for a live drive, guard it anyway
    if (s6_valid && s6_den) begin
      den_q <= (tanh_v == '0) ? atw_pkg::TANH_W'(1) : tanh_v;
    end

    dv_rem[0]  <= dividend;
    dv_q[0]    <= '0;
    dv_side[0] <= div_side_in;
  end

  // ---------------------------------------------------------------------------
  // Restoring divider, one quotient bit per stage
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int B = QW - 1 - k;
    logic [32:0] den_sh;
    logic        take;

    assign den_sh = {16'd0, den_q} << B;
    assign take   = {1'b0, dv_rem[k]} >= den_sh;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[k+1] <= 1'b0;
      end else begin
        dv_valid[k+1] <= dv_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      dv_rem[k+1]  <= take ? dv_rem[k] - den_sh[atw_pkg::NUM_W-1:0] : dv_rem[k];
      dv_q[k+1]    <= dv_q[k] | (QW'(take) << B);
      dv_side[k+1] <= dv_side[k];
    end
  end

  // ---------------------------------------------------------------------------
  // Sign, saturation and output register
  // ---------------------------------------------------------------------------
  atw_pkg::side_t                   fin_side;
  logic [QW-1:0]                    q_clip;
  logic signed [atw_pkg::OUT_W:0]   q_signed;
  logic signed [atw_pkg::OUT_W-1:0] shaped;

  assign fin_side = dv_side[QW];
  assign q_clip   = (fin_side.ovf || dv_q[QW] > atw_pkg::TANH_ONE) ? atw_pkg::TANH_ONE
                                                                   : dv_q[QW];
  assign q_signed = fin_side.neg ? -$signed({1'b0, q_clip}) : $signed({1'b0, q_clip});

  always_comb begin
    if (fin_side.bypass) begin
      shaped = fin_side.y;
    end else if (q_signed > atw_pkg::OUT_MAX) begin
      shaped = atw_pkg::OUT_MAX[atw_pkg::OUT_W-1:0];
    end else begin
      shaped = q_signed[atw_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_valid[QW];
    end
  end

  always_ff @(posedge clk) begin
    sample_out <= shaped;
  end

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LATENCY done)
    else $error("accepted word did not leave after the pipeline latency");

  a_divisor: assert property (@(posedge clk) disable iff (rst)
    dv_valid[0] |-> den_q != '0)
    else $error("word entered the divider without a valid divisor");

  a_refresh: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && cfg_index == atw_pkg::REG_DRIVE |=> busy)
    else $error("drive write did not hold off input for the divisor refresh");
`endif

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for asymmetric_tanh_waveshaper: predicts each shaped sample
// from the register settings and compares every result word against it.
// Depends on atw_pkg and the asymmetric_tanh_waveshaper RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TANH_N = 256;
  localparam logic [atw_pkg::CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [atw_pkg::CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;
  localparam longint SHAPE_MIN = -65536;
  localparam longint SHAPE_MAX = 32767;

  typedef struct {
    logic signed [atw_pkg::SAMPLE_W-1:0] x;
    logic signed [atw_pkg::OUT_W-1:0]    shaped;
  } shaped_word_t;

  class waveshape_checker;
    longint unsigned tanh_lut[TANH_N];
    logic [15:0]     asym;
    logic [15:0]     drive;
    shaped_word_t    pending_out[$];
    int              errors;
    int              checked;
    int              tanh_items;
    int              bypass_items;

    function new();
      asym  = atw_pkg::ASYMMETRY_RESET;
      drive = atw_pkg::DRIVE_RESET;
      build_lut();
    endfunction

    // tanh(8i/(N-1)) in Q.16 via a Taylor series for e^-r and eight squarings
    function void build_lut();
      longint unsigned span, r, acc, term, den, num;
      span = TANH_N - 1;
      for (int i = 0; i < TANH_N; i++) begin
        r = (64'(i) * (64'd1 << 26) + span / 2) / span;
        acc = atw_pkg::ONE_Q30;
        term = atw_pkg::ONE_Q30;
        for (int n = 1; n <= 6; n++) begin
          term = (term * r) / (64'(n) << 30);
          if (n % 2 == 1) acc = acc - term;
          else acc = acc + term;
        end
        repeat (8) acc = (acc * acc + (64'd1 << 29)) >> 30;
        den = atw_pkg::ONE_Q30 + acc;
        num = (atw_pkg::ONE_Q30 - acc) << 16;
        tanh_lut[i] = (num + den / 2) / den;
      end
    endfunction

    // z in Q.27, result in Q.16, odd symmetry, 1.0 beyond the table
    function longint tanh_q16(longint z);
      longint unsigned mag, p, idx, f, v;
      if (z < 0) mag = -z;
      else mag = z;
      if (mag >= atw_pkg::ONE_Q30) begin
        v = 65536;
      end else begin
        p = mag * (TANH_N - 1);
        idx = p >> 30;
        f = p & (atw_pkg::ONE_Q30 - 1);
        if (idx > TANH_N - 2) idx = TANH_N - 2;
        v = (tanh_lut[idx] * (atw_pkg::ONE_Q30 - f) + tanh_lut[idx + 1] * f
             + (64'd1 << 29)) >> 30;
      end
      return (z < 0) ? -longint'(v) : longint'(v);
    endfunction

    function logic signed [atw_pkg::OUT_W-1:0] shape(logic signed [atw_pkg::SAMPLE_W-1:0] x);
      longint xs, y, d, res, num_t, den_t;
      longint unsigned sq, t, mag, q;
      xs = x;
      d = drive;
      sq = xs * xs;
      t = (64'(asym) * sq + atw_pkg::ONE_Q30) >> 31;
      y = xs - longint'(t);
      if (drive > atw_pkg::DRIVE_BYPASS_MAX) begin
        num_t = tanh_q16(y * d);
        den_t = tanh_q16(d << 15);
        if (den_t <= 0) den_t = 1;
        if (num_t < 0) mag = -num_t;
        else mag = num_t;
        q = (mag * 32768 + den_t / 2) / den_t;
        if (q > 65536) q = 65536;
        res = (num_t < 0) ? -longint'(q) : longint'(q);
      end else begin
        res = y;
      end
      if (res < SHAPE_MIN) res = SHAPE_MIN;
      if (res > SHAPE_MAX) res = SHAPE_MAX;
      return res[atw_pkg::OUT_W-1:0];
    endfunction

    function void set_reg(logic [atw_pkg::CFG_INDEX_W-1:0] index, logic [15:0] data);
      if (index == atw_pkg::REG_ASYMMETRY) asym = data;
      else if (index == atw_pkg::REG_DRIVE) drive = data;
    endfunction

    function void note_sample(logic signed [atw_pkg::SAMPLE_W-1:0] x);
      shaped_word_t w;
      w.x = x;
      w.shaped = shape(x);
      pending_out.push_back(w);
      if (drive > atw_pkg::DRIVE_BYPASS_MAX) tanh_items++;
      else bypass_items++;
    endfunction

    function void check_out(logic signed [atw_pkg::OUT_W-1:0] actual);
      shaped_word_t w;
      if (pending_out.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %0d", actual);
        return;
      end
      w = pending_out.pop_front();
      checked++;
      if (actual !== w.shaped) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: sample_in %0d asym %0d drive %0d expected %0d got %0d",
                   w.x, asym, drive, w.shaped, actual);
      end
    endfunction
  endclass

  logic                                clk;
  logic                                rst = 1'b1;
  logic                                start = 1'b0;
  logic signed [atw_pkg::SAMPLE_W-1:0] sample_in = '0;
  logic                                busy;
  logic                                done;
  logic signed [atw_pkg::OUT_W-1:0]    sample_out;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [atw_pkg::CFG_INDEX_W-1:0]     cfg_index = '0;
  logic [15:0]                         cfg_data = '0;

  waveshape_checker board = new();
  int settings_seen = 0;
  logic signed [atw_pkg::SAMPLE_W-1:0] corner_x [9] = '{16'sh0000, 16'sh0001, 16'shFFFF,
                                                        16'sh7FFF, 16'sh8000, 16'sh4000,
                                                        16'shC000, 16'sh5555, 16'shAAAA};

  asymmetric_tanh_waveshaper #(.TANH_POINTS(TANH_N)) dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .sample_in  (sample_in),
    .busy       (busy),
    .done       (done),
    .sample_out (sample_out),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && done) board.check_out(sample_out);
  end

  function automatic int pick_gap(bit steady);
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 4);
    return $urandom_range(5, 60);
  endfunction

  function automatic logic signed [atw_pkg::SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'(32767 - int'($urandom_range(0, 31)));
      1: return 16'(-32768 + int'($urandom_range(0, 31)));
      2: return 16'(int'($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  // hold start high straight into the next word when there is no gap
  task automatic send_sample(logic signed [atw_pkg::SAMPLE_W-1:0] x, int gap);
    start <= 1'b1;
    sample_in <= x;
    do @(posedge clk); while (busy);
    board.note_sample(x);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (board.pending_out.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [atw_pkg::CFG_INDEX_W-1:0] index, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.set_reg(index, data);
  endtask

  // drive last: its write kicks off the divisor refresh
  task automatic apply_settings(logic [15:0] a_code, logic [15:0] d_code);
    wait_idle();
    write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 16'($urandom));
    write_reg(atw_pkg::REG_ASYMMETRY, a_code);
    write_reg(atw_pkg::REG_DRIVE, d_code);
    settings_seen++;
  endtask

  initial begin
    logic [15:0] a_code, d_code;
    bit          steady;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // corners at the reset settings, back to back
    settings_seen = 1;
    foreach (corner_x[j]) send_sample(corner_x[j], 0);
    apply_settings(16'hFFFF, atw_pkg::DRIVE_BYPASS_MAX);
    for (int j = 1; j < 5; j++) send_sample(corner_x[j], pick_gap(0));
    apply_settings(16'h0000, atw_pkg::DRIVE_BYPASS_MAX + 16'd1);
    for (int j = 1; j < 5; j++) send_sample(corner_x[j], pick_gap(0));
    apply_settings(16'hFFFF, 16'hFFFF);
    for (int j = 1; j < 5; j++) send_sample(corner_x[j], pick_gap(0));
    apply_settings(16'h0000, 16'h0000);
    for (int j = 1; j < 5; j++) send_sample(corner_x[j], pick_gap(0));

    for (int p = 0; p < 10; p++) begin
      case (p % 5)
        0: d_code = 16'($urandom_range(0, 40));
        1: d_code = atw_pkg::DRIVE_BYPASS_MAX + 16'd1;
        2: d_code = 16'hFFFF;
        3: d_code = 16'($urandom_range(41, 8192));
        default: d_code = 16'($urandom);
      endcase
      if (p % 3 == 0) a_code = (p % 2 == 0) ? 16'h0000 : 16'hFFFF;
      else a_code = 16'($urandom);
      apply_settings(a_code, d_code);
      steady = (p % 4 == 1);
      repeat (50) send_sample(pick_sample(), pick_gap(steady));
    end

    wait_idle();
    repeat (40) @(posedge clk);
    $display("Checked %0d shaped samples over %0d register settings", board.checked,
             settings_seen);
    $display("%0d through the tanh path, %0d bypassed, %0d errors", board.tanh_items,
             board.bypass_items, board.errors);
    if (board.errors == 0 && board.pending_out.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout with %0d words outstanding", board.pending_out.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
